// ===== src/ltwf_pkg.sv =====
// shared types and constants for the lin transport write framer
`timescale 1ns / 1ps
`default_nettype none

package ltwf_pkg;

  // micro-operations of the sequencer
  typedef enum logic [2:0] {
    OP_WAIT      = 3'd0,
    OP_SUM_FIRST = 3'd1,
    OP_SUM       = 3'd2,
    OP_SUM_END   = 3'd3,
    OP_HEAD      = 3'd4,
    OP_EMIT      = 3'd5
  } op_t;

  // one control word of the program
  typedef struct packed {
    op_t        op;
    logic [2:0] grp;  // six-byte group of the message block
    logic       fin;  // final step, jump back to the wait step
  } ucode_t;

  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 11;

  // action codes
  localparam logic [1:0] ACT_POLL  = 2'd0;
  localparam logic [1:0] ACT_ARM   = 2'd1;
  localparam logic [1:0] ACT_CLOCK = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_AIRCON_MODE = 3'd0;
  localparam logic [2:0] REG_VENT_MODE   = 3'd1;
  localparam logic [2:0] REG_UNIT_ON     = 3'd2;
  localparam logic [2:0] REG_TARGET_TEMP = 3'd3;
  localparam logic [2:0] REG_TIME_FMT    = 3'd4;

endpackage

`default_nettype wire

// ===== src/ltwf_seq.sv =====
// microcoded sequencer: step counter and program rom
`timescale 1ns / 1ps
`default_nettype none

module ltwf_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire logic            out_free,
  output ltwf_pkg::ucode_t     uc
);
  import ltwf_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              adv;

  function automatic ucode_t rom(input logic [STEP_W-1:0] s);
    ucode_t w;
    w = '{op: OP_WAIT, grp: 3'd0, fin: 1'b0};
    case (s)
      4'd0:    w = '{op: OP_WAIT,      grp: 3'd0, fin: 1'b0};
      4'd1:    w = '{op: OP_SUM_FIRST, grp: 3'd1, fin: 1'b0};
      4'd2:    w = '{op: OP_SUM,       grp: 3'd2, fin: 1'b0};
      4'd3:    w = '{op: OP_SUM_END,   grp: 3'd3, fin: 1'b0};
      4'd4:    w = '{op: OP_HEAD,      grp: 3'd0, fin: 1'b0};
      4'd5:    w = '{op: OP_EMIT,      grp: 3'd0, fin: 1'b0};
      4'd6:    w = '{op: OP_EMIT,      grp: 3'd1, fin: 1'b0};
      4'd7:    w = '{op: OP_EMIT,      grp: 3'd2, fin: 1'b0};
      4'd8:    w = '{op: OP_EMIT,      grp: 3'd3, fin: 1'b0};
      4'd9:    w = '{op: OP_EMIT,      grp: 3'd4, fin: 1'b0};
      4'd10:   w = '{op: OP_EMIT,      grp: 3'd5, fin: 1'b1};
      default: w = '{op: OP_WAIT,      grp: 3'd0, fin: 1'b0};
    endcase
    return w;
  endfunction

  assign uc = rom(step_r);

  always_comb begin
    case (uc.op)
      OP_WAIT:          adv = go;
      OP_HEAD, OP_EMIT: adv = out_free;
      default:          adv = 1'b1;
    endcase
    step_nxt = step_r;
    if (adv) begin
      step_nxt = uc.fin ? '0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

  // steps stay inside the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r < STEP_W'(NUM_STEPS))
    else $error("sequencer step out of program");

  // a start always leaves the wait step
  a_go_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> step_r == STEP_W'(1))
    else $error("start did not enter the checksum pass");

  // wait step only moves on a start
  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.op == OP_WAIT) && !go |=> step_r == '0)
    else $error("wait step advanced without start");

endmodule

`default_nettype wire

// ===== src/lin_transport_write_framer_top.sv =====
// top level of the lin transport write framer: event handling, block datapath, frame output
// an arm or clock-sync event, an idle poll and an unused action are taken in the wait step
// a poll with an upload pending runs the 11-step program: the wait step, 3 steps of block checksum
// (six bytes a step), then 7 frame steps; the first frame is registered in the head step after
// the checksum steps, and no new item is taken until the program returns to wait
// output back-pressure stretches each frame step
// reset: rst_n synchronous, active low; all control and config state cleared, unit_on set to 1
`timescale 1ns / 1ps
`default_nettype none

module lin_transport_write_framer_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // action[1:0], clock_hour[6:2], clock_minute[12:7],
                                       // clock_second[18:13], zero fill
  // frames
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // node_address[7:0], control_byte[15:8],
                                       // payload[63:16], frame_check[71:64]
  output logic             out_tlast,  // last frame of a run
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import ltwf_pkg::*;

  localparam logic [7:0]  NODE_ADDR   = 8'h03;
  localparam logic [7:0]  CTRL_FIRST  = 8'h10;
  localparam logic [7:0]  CTRL_CONSEC = 8'h21;
  localparam logic [47:0] HEAD_PAY    = 48'h1E_00_1F_00_FA_29;
  localparam logic [47:0] PREAMBLE_LO = 48'hFF_FF_FF_22_00_00;

  // configuration registers
  logic [2:0]  aircon_mode_r;
  logic [7:0]  vent_mode_r;
  logic        unit_on_r;
  logic [15:0] target_temp_r;
  logic        time_fmt_r;

  // upload state
  logic [7:0]  cmd_cnt_r, cmd_cnt_nxt;
  logic [1:0]  clim_left_r, clim_left_nxt;
  logic [1:0]  clk_left_r, clk_left_nxt;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic        climate_r, climate_nxt;

  // datapath
  logic [7:0]  acc_r;
  logic [7:0]  blk_csum_r;
  logic        out_tvalid_r;
  logic [71:0] out_tdata_r;
  logic        out_tlast_r;

  ucode_t      uc;
  logic        in_xfer, go, out_free;
  logic [1:0]  act;
  logic [7:0]  csum_src;
  logic [47:0] grp_word;
  logic [7:0]  b12, b13, b14, b15, b16, b17, b18;
  logic [10:0] blk_sum;
  logic [7:0]  blk_fold;
  logic [7:0]  frm_ctrl;
  logic [47:0] frm_pay;
  logic [10:0] frm_sum;
  logic [7:0]  frm_check;

  // end-around carry fold of a byte sum
  function automatic logic [7:0] fold(input logic [10:0] x);
    logic [8:0] t;
    t = {1'b0, x[7:0]} + {6'b0, x[10:8]};
    return t[7:0] + {7'b0, t[8]};
  endfunction

  function automatic logic [10:0] sum6(input logic [47:0] w);
    logic [10:0] s;
    s = '0;
    for (int b = 0; b < 6; b++) begin
      s = s + {3'b0, w[8*b +: 8]};
    end
    return s;
  endfunction

  ltwf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .out_free (out_free),
    .uc       (uc)
  );

  assign in_tready = (uc.op == OP_WAIT);
  assign in_xfer   = in_tvalid && in_tready;
  assign act       = in_tdata[1:0];
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  // event handling and poll arbitration, climate before clock
  always_comb begin
    cmd_cnt_nxt   = cmd_cnt_r;
    clim_left_nxt = clim_left_r;
    clk_left_nxt  = clk_left_r;
    climate_nxt   = climate_r;
    go            = 1'b0;
    if (in_xfer) begin
      case (act)
        ACT_ARM:   clim_left_nxt = 2'd2;
        ACT_CLOCK: clk_left_nxt  = 2'd2;
        ACT_POLL: begin
          if (clim_left_r != 2'd0) begin
            clim_left_nxt = clim_left_r - 2'd1;
            climate_nxt   = 1'b1;
            go            = 1'b1;
          end else if (clk_left_r != 2'd0) begin
            clk_left_nxt = clk_left_r - 2'd1;
            climate_nxt  = 1'b0;
            go           = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (go) begin
      // counter runs modulo 255
      cmd_cnt_nxt = (cmd_cnt_r == 8'd254) ? 8'd0 : cmd_cnt_r + 8'd1;
    end
  end

  // message block bytes 12..18, the climate settings or the clock time
  always_comb begin
    if (climate_r) begin
      b12 = {5'b0, aircon_mode_r};
      b13 = 8'h00;
      b14 = vent_mode_r;
      b15 = {7'b0, unit_on_r};
      b16 = target_temp_r[7:0];
      b17 = target_temp_r[15:8];
      b18 = 8'h00;
    end else begin
      b12 = {3'b0, hour_r};
      b13 = {2'b0, minute_r};
      b14 = {2'b0, second_r};
      b15 = 8'h01;
      b16 = 8'h01;
      b17 = 8'h00;
      b18 = {7'b0, time_fmt_r};
    end
  end

  // block checksum byte reads as zero while it is being summed
  assign csum_src = (uc.op == OP_EMIT) ? blk_csum_r : 8'h00;

  always_comb begin
    case (uc.grp)
      3'd0:    grp_word = PREAMBLE_LO;
      3'd1:    grp_word = {csum_src, cmd_cnt_r, climate_r ? 8'h34 : 8'h14,
                           climate_r ? 8'h0C : 8'h0A, 8'h01, 8'h54};
      3'd2:    grp_word = {b17, b16, b15, b14, b13, b12};
      3'd3:    grp_word = {40'h0, b18};
      default: grp_word = 48'h0;
    endcase
  end

  assign blk_sum  = sum6(grp_word) + ((uc.op == OP_SUM_FIRST) ? 11'd0 : {3'b0, acc_r});
  assign blk_fold = fold(blk_sum);

  assign frm_ctrl  = (uc.op == OP_HEAD) ? CTRL_FIRST : CTRL_CONSEC + {5'b0, uc.grp};
  assign frm_pay   = (uc.op == OP_HEAD) ? HEAD_PAY : grp_word;
  assign frm_sum   = sum6(frm_pay) + {3'b0, NODE_ADDR} + {3'b0, frm_ctrl};
  assign frm_check = ~fold(frm_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aircon_mode_r <= '0;
      vent_mode_r   <= '0;
      unit_on_r     <= 1'b1;
      target_temp_r <= '0;
      time_fmt_r    <= 1'b0;
      cmd_cnt_r     <= '0;
      clim_left_r   <= '0;
      clk_left_r    <= '0;
      hour_r        <= '0;
      minute_r      <= '0;
      second_r      <= '0;
      climate_r     <= 1'b0;
      out_tvalid_r  <= 1'b0;
      out_tlast_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AIRCON_MODE: aircon_mode_r <= cfg_data[2:0];
          REG_VENT_MODE:   vent_mode_r   <= cfg_data[7:0];
          REG_UNIT_ON:     unit_on_r     <= cfg_data[0];
          REG_TARGET_TEMP: target_temp_r <= cfg_data;
          REG_TIME_FMT:    time_fmt_r    <= cfg_data[0];
          default: ;
        endcase
      end
      cmd_cnt_r   <= cmd_cnt_nxt;
      clim_left_r <= clim_left_nxt;
      clk_left_r  <= clk_left_nxt;
      climate_r   <= climate_nxt;
      if (in_xfer && act == ACT_CLOCK) begin
        hour_r   <= in_tdata[6:2];
        minute_r <= in_tdata[12:7];
        second_r <= in_tdata[18:13];
      end
      // output register, loaded on a frame step when free
      if ((uc.op == OP_HEAD || uc.op == OP_EMIT) && out_free) begin
        out_tvalid_r <= 1'b1;
        out_tlast_r  <= uc.fin;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // checksum pass and frame payload need no reset
  always_ff @(posedge clk) begin
    if (uc.op == OP_SUM_FIRST || uc.op == OP_SUM) begin
      acc_r <= blk_fold;
    end
    if (uc.op == OP_SUM_END) begin
      blk_csum_r <= ~blk_fold;
    end
    if ((uc.op == OP_HEAD || uc.op == OP_EMIT) && out_free) begin
      out_tdata_r <= {frm_check, frm_pay, frm_ctrl, NODE_ADDR};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // counter stays inside its modulo range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_cnt_r != 8'hFF)
    else $error("command counter reached 255");

  // pending counts never exceed two
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    clim_left_r != 2'd3 && clk_left_r != 2'd3)
    else $error("send count above two");

  // a poll with nothing pending leaves the block ready
  a_idle_poll: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && act == ACT_POLL && clim_left_r == 2'd0 && clk_left_r == 2'd0
      |=> in_tready)
    else $error("idle poll started a run");

  // a started run counts the command
  a_go_count: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> cmd_cnt_r != $past(cmd_cnt_r))
    else $error("run started without counter bump");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// self-checking bench for the lin transport write framer: frame predictor, stream drivers, checker
`timescale 1ns / 1ps

module tb_top;
  import ltwf_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // register index outside the map, writes to it must be dropped
  localparam logic [2:0] REG_UNUSED = 3'd7;

  // fixed parts of every run
  localparam logic [63:0] PREAMBLE      = 64'h0154_FFFF_FF22_0000;  // byte 0 in low octet
  localparam logic [47:0] FIRST_PAYLOAD = 48'h1E00_1F00_FA29;
  localparam logic [7:0]  NODE_ADDR     = 8'h03;
  localparam logic [7:0]  CTL_FIRST     = 8'h10;
  localparam logic [7:0]  CTL_CONSEC    = 8'h21;
  localparam logic [7:0]  HDR_CLIMATE_0 = 8'h0C;
  localparam logic [7:0]  HDR_CLIMATE_1 = 8'h34;
  localparam logic [7:0]  HDR_CLOCK_0   = 8'h0A;
  localparam logic [7:0]  HDR_CLOCK_1   = 8'h14;
  localparam logic [1:0]  SENDS_PER_ARM = 2'd2;
  localparam int          RUN_LEN       = 7;

  // bench limits
  localparam int         DIR_ROWS       = 25;
  localparam int         PART_B_ROW     = 19;
  localparam int         RANDOM_ITEMS   = 216;
  localparam int         NUM_PHASES     = 4;
  localparam int         SETTLE_CYCLES  = 16;
  localparam int         END_SETTLE     = 32;
  localparam int         LONG_HOLD      = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         MAX_REPORTS    = 60;
  localparam logic [3:0] FRAMES_FREE    = 4'hF;  // row has no typed frame count

  typedef struct packed {
    logic [7:0]  node;
    logic [7:0]  ctl;
    logic [47:0] payload;
    logic [7:0]  fchk;
    logic        last;
  } lin_frame_t;

  typedef struct packed {
    logic [1:0] act;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [3:0] frames;  // typed frame count, or FRAMES_FREE
  } stim_row_t;

  // ---------------------------------------------------------------------------
  // dut hookup
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // action[1:0], clock_hour[6:2], clock_minute[12:7],
                           // clock_second[18:13], zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;  // node_address[7:0], control_byte[15:8],
                           // payload[63:16], frame_check[71:64]
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  lin_transport_write_framer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the block: configuration and upload state
  // ---------------------------------------------------------------------------
  logic [2:0]  sh_aircon;
  logic [7:0]  sh_vent;
  logic        sh_unit_on;
  logic [15:0] sh_temp;
  logic        sh_time_fmt;
  logic [7:0]  sh_cmd_count;
  logic [1:0]  sh_climate_left;
  logic [1:0]  sh_clock_left;
  logic [7:0]  sh_hour;
  logic [7:0]  sh_minute;
  logic [7:0]  sh_second;

  // frames still owed by the block, oldest first
  lin_frame_t owed_frames[$];

  // run statistics
  int items_taken;
  int counted_items;
  int climate_runs;
  int clock_runs;
  int frames_checked;
  int cfg_writes;
  int err_count;

  // traffic shaping shared by the sender and the receiver
  bit no_idle;
  bit hold_req;

  // one line per mismatch up to MAX_REPORTS, all of them counted
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // lin classic add: carry out of bit 7 goes back in at bit 0
  function automatic logic [7:0] wrap_add(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, acc} + {1'b0, b};
    if (t > 9'd255) t = t - 9'd255;
    return t[7:0];
  endfunction

  // queue one frame with its frame checksum
  function automatic void owe_frame(input logic [7:0] ctl, input logic [47:0] pay,
                                    input logic last);
    lin_frame_t f;
    logic [7:0] acc;
    int i;
    acc = wrap_add(8'd0, NODE_ADDR);
    acc = wrap_add(acc, ctl);
    for (i = 0; i < 6; i++) acc = wrap_add(acc, pay[8*i +: 8]);
    f.node    = NODE_ADDR;
    f.ctl     = ctl;
    f.payload = pay;
    f.fchk    = ~acc;
    f.last    = last;
    owed_frames = {owed_frames, f};
  endfunction

  // one upload: counter bump, 36-byte message block, seven frames
  function automatic void owe_upload(input bit climate);
    logic [7:0]  blk [36];
    logic [7:0]  acc;
    logic [47:0] pay;
    int i;
    int k;
    sh_cmd_count = (sh_cmd_count == 8'd254) ? 8'd0 : sh_cmd_count + 8'd1;
    for (i = 0; i < 8; i++) blk[i] = PREAMBLE[8*i +: 8];
    for (i = 8; i < 36; i++) blk[i] = 8'd0;
    // content starts at block byte 10
    blk[10] = sh_cmd_count;
    if (climate) begin
      blk[8]  = HDR_CLIMATE_0;
      blk[9]  = HDR_CLIMATE_1;
      blk[12] = {5'd0, sh_aircon};
      blk[14] = sh_vent;
      blk[15] = {7'd0, sh_unit_on};
      blk[16] = sh_temp[7:0];
      blk[17] = sh_temp[15:8];
    end else begin
      blk[8]  = HDR_CLOCK_0;
      blk[9]  = HDR_CLOCK_1;
      blk[12] = sh_hour;
      blk[13] = sh_minute;
      blk[14] = sh_second;
      blk[15] = 8'd1;
      blk[16] = 8'd1;
      blk[18] = {7'd0, sh_time_fmt};
    end
    // block checksum over bytes 6..35 lands in byte 11
    acc = 8'd0;
    for (i = 6; i < 36; i++) acc = wrap_add(acc, blk[i]);
    blk[11] = ~acc;
    owe_frame(CTL_FIRST, FIRST_PAYLOAD, 1'b0);
    for (k = 0; k < 6; k++) begin
      for (i = 0; i < 6; i++) pay[8*i +: 8] = blk[6*k + i];
      owe_frame(CTL_CONSEC + 8'(k), pay, k == 5);
    end
  endfunction

  // predicted frame count of one accepted item, frames queued as a side effect
  function automatic int predict_frames(input logic [1:0] act, input logic [4:0] hour,
                                        input logic [5:0] minute, input logic [5:0] second);
    int n;
    n = 0;
    case (act)
      ACT_ARM: begin
        sh_climate_left = SENDS_PER_ARM;
      end
      ACT_CLOCK: begin
        sh_hour       = {3'd0, hour};
        sh_minute     = {2'd0, minute};
        sh_second     = {2'd0, second};
        sh_clock_left = SENDS_PER_ARM;
      end
      ACT_POLL: begin
        // climate is served ahead of the clock
        if (sh_climate_left != 2'd0) begin
          sh_climate_left--;
          owe_upload(1'b1);
          climate_runs++;
          n = RUN_LEN;
        end else if (sh_clock_left != 2'd0) begin
          sh_clock_left--;
          owe_upload(1'b0);
          clock_runs++;
          n = RUN_LEN;
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: one transfer per call, valid left high when the next gap is zero
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] act, input logic [4:0] hour,
                           input logic [5:0] minute, input logic [5:0] second,
                           output int n);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, second, minute, hour, act};
    do @(posedge clk); while (!in_tready);
    items_taken++;
    if (act != ACT_UNUSED) counted_items++;
    n = predict_frames(act, hour, minute, second);
  endtask

  // park the input, let every owed frame out and the program fall back to wait
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (owed_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // full register setting, written back to back; the off-map write must change nothing
  task automatic write_config(input logic [2:0] aircon, input logic [7:0] vent,
                              input logic unit_on, input logic [15:0] temp,
                              input logic time_fmt);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    int i;
    idx = '{REG_AIRCON_MODE, REG_VENT_MODE, REG_UNIT_ON, REG_TARGET_TEMP,
            REG_TIME_FMT, REG_UNUSED};
    val = '{{13'd0, aircon}, {8'd0, vent}, {15'd0, unit_on}, temp,
            {15'd0, time_fmt}, 16'($urandom)};
    for (i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid   <= 1'b0;
    sh_aircon   = aircon;
    sh_vent     = vent;
    sh_unit_on  = unit_on;
    sh_temp     = temp;
    sh_time_fmt = time_fmt;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stalls per frame, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : frame_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        // long hold so the block backs up and blocks its input
        stall    = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 4);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // frame checker: every transfer against the oldest owed frame
  always @(posedge clk) begin
    lin_frame_t want;
    if (rst_n && out_tvalid && out_tready) begin
      frames_checked++;
      if (owed_frames.size() == 0) begin
        report_mismatch("frame with nothing owed, control byte", {56'd0, out_tdata[15:8]},
                        64'd0);
      end else begin
        want = owed_frames.pop_front();
        if (out_tdata[7:0] !== want.node)
          report_mismatch("node address", {56'd0, out_tdata[7:0]}, {56'd0, want.node});
        if (out_tdata[15:8] !== want.ctl)
          report_mismatch("control byte", {56'd0, out_tdata[15:8]}, {56'd0, want.ctl});
        if (out_tdata[63:16] !== want.payload)
          report_mismatch("payload", {16'd0, out_tdata[63:16]}, {16'd0, want.payload});
        if (out_tdata[71:64] !== want.fchk)
          report_mismatch("frame check", {56'd0, out_tdata[71:64]}, {56'd0, want.fchk});
        if (out_tlast !== want.last)
          report_mismatch("last flag", {63'd0, out_tlast}, {63'd0, want.last});
      end
    end
  end

  // watchdog: too long without any transfer on any channel ends the run
  int quiet_cycles;
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: %0d quiet cycles, %0d frames still owed", quiet_cycles,
               owed_frames.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [DIR_ROWS];

  initial begin : stimulus
    int n;
    int r;
    int ph;
    int pick;
    int polls;
    int phase_end;
    bit hold_sent;

    // every input known from time zero
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    no_idle   = 1'b0;
    hold_req  = 1'b0;
    hold_sent = 1'b0;

    // shadow state after reset
    sh_aircon       = '0;
    sh_vent         = '0;
    sh_unit_on      = 1'b1;
    sh_temp         = '0;
    sh_time_fmt     = 1'b0;
    sh_cmd_count    = '0;
    sh_climate_left = '0;
    sh_clock_left   = '0;
    sh_hour         = '0;
    sh_minute       = '0;
    sh_second       = '0;
    items_taken     = 0;
    counted_items   = 0;
    climate_runs    = 0;
    clock_runs      = 0;
    frames_checked  = 0;
    cfg_writes      = 0;
    err_count       = 0;

    // directed rows; first part runs on reset settings, second on the top extremes
    dir_rows = '{
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  4'd0},         // poll straight after reset
      '{ACT_UNUSED, 5'd31, 6'd63, 6'd63, 4'd0},         // unused action, all ones
      '{ACT_ARM,    5'd0,  6'd0,  6'd0,  4'd0},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  4'd7},         // first climate upload
      '{ACT_CLOCK,  5'd23, 6'd59, 6'd59, 4'd0},         // last valid time of day
      '{ACT_POLL,   5'd31, 6'd63, 6'd63, 4'd7},         // climate still ahead of clock
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  4'd0},         // both counts used up
      '{ACT_CLOCK,  5'd31, 6'd63, 6'd63, 4'd0},         // time out of range, kept as given
      '{ACT_ARM,    5'd0,  6'd0,  6'd0,  4'd0},
      '{ACT_ARM,    5'd31, 6'd63, 6'd63, 4'd0},         // repeated arm does not add up
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},  // clock, out-of-range time
      '{ACT_CLOCK,  5'd0,  6'd0,  6'd0,  4'd0},         // repeated sync reloads two sends
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  4'd0},
      '{ACT_ARM,    5'd0,  6'd0,  6'd0,  4'd0},         // top extremes from here
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_CLOCK,  5'd12, 6'd30, 6'd45, 4'd0},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE},
      '{ACT_POLL,   5'd0,  6'd0,  6'd0,  FRAMES_FREE}
    };

    // reset held low from time zero, released once and never again
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      if (r == PART_B_ROW) begin
        drain_block();
        write_config(3'd7, 8'd255, 1'b1, 16'hFFFF, 1'b1);
      end
      send_item(dir_rows[r].act, dir_rows[r].hour, dir_rows[r].minute,
                dir_rows[r].second, n);
      if (dir_rows[r].frames != FRAMES_FREE && n != int'(dir_rows[r].frames))
        report_mismatch("directed frame count", 64'(n), {60'd0, dir_rows[r].frames});
    end

    // random phases: mostly arm or sync followed by polls, some stray polls and noise
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      if (ph == 1)
        write_config(3'd0, 8'd0, 1'b0, 16'd0, 1'b0);  // bottom extremes
      else
        write_config(3'($urandom), 8'($urandom), 1'($urandom), 16'($urandom),
                     1'($urandom));
      // no idling at all in the bottom-extreme phase, both kinds mixed in the last one
      no_idle   = (ph == 1);
      phase_end = counted_items + RANDOM_ITEMS / NUM_PHASES;
      while (counted_items < phase_end) begin
        if (ph == NUM_PHASES - 1) no_idle = 1'($urandom);
        if (ph == 1 && !hold_sent && counted_items > phase_end - 50) begin
          hold_req  = 1'b1;
          hold_sent = 1'b1;
        end
        pick  = $urandom_range(0, 99);
        polls = 0;
        if (pick < 30) begin
          send_item(ACT_ARM, 5'($urandom), 6'($urandom), 6'($urandom), n);
          polls = $urandom_range(1, 3);
        end else if (pick < 60) begin
          send_item(ACT_CLOCK, 5'($urandom), 6'($urandom), 6'($urandom), n);
          polls = $urandom_range(1, 3);
        end else if (pick < 78) begin
          send_item(ACT_ARM, 5'($urandom), 6'($urandom), 6'($urandom), n);
          send_item(ACT_CLOCK, 5'($urandom), 6'($urandom), 6'($urandom), n);
          polls = $urandom_range(2, 5);
        end else if (pick < 90) begin
          polls = 1;
        end else begin
          send_item(ACT_UNUSED, 5'($urandom), 6'($urandom), 6'($urandom), n);
        end
        repeat (polls)
          send_item(ACT_POLL, 5'($urandom), 6'($urandom), 6'($urandom), n);
      end
    end

    // all stimulus in: wait for the owed frames, then a quiet tail for strays
    no_idle = 1'b0;
    drain_block();
    repeat (END_SETTLE) @(posedge clk);

    $display("covered %0d items: %0d climate and %0d clock uploads, %0d frames checked",
             items_taken, climate_runs, clock_runs, frames_checked);
    $display("%0d register writes over %0d settings, one %0d-cycle output hold",
             cfg_writes, NUM_PHASES + 1, LONG_HOLD);
    if (err_count == 0 && owed_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
